@@ sv/assert_macros.svh @@
// Assertion macros shared by the color signature learner RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define HSSLC_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked at every rising edge outside reset.
`define HSSLC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

@@ sv/hsslc_pkg.sv @@
// Package with the constants and types of the color signature learner.
`timescale 1ns / 1ps
package hsslc_pkg;

   localparam int REGION_PIXELS  = 4096;
   localparam int NUM_SIGNATURES = 3;

   localparam int ADDR_W  = (REGION_PIXELS > 1) ? $clog2(REGION_PIXELS) : 1;
   localparam int COUNT_W = $clog2(REGION_PIXELS + 1);
   localparam int RATIO_W = 7;
   localparam int NEED_W  = COUNT_W + RATIO_W;
   localparam int PIX_W   = 8;
   localparam int SEL_W   = 2;
   localparam int BND_W   = 10;
   localparam int OUT_W   = 12;
   localparam int STEP_W  = 8;

   localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(80);
   localparam logic [STEP_W-1:0]  FIRST_STEP  = STEP_W'(128);
   localparam int PASS_PERCENT = 100;
   localparam int HUE_WIDEN    = 2;
   localparam int SAT_WIDEN    = 3;

   localparam logic OP_LEARN    = 1'b0;
   localparam logic OP_CLASSIFY = 1'b1;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_RATIO_IDX = 1'b0;

   typedef struct packed {
      logic [PIX_W-1:0] hue;
      logic [PIX_W-1:0] sat;
   } sample_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] hue_low;
      logic signed [OUT_W-1:0] hue_high;
      logic signed [OUT_W-1:0] sat_low;
      logic signed [OUT_W-1:0] sat_high;
   } bounds_type;

   typedef struct packed {
      logic               start;
      logic [COUNT_W-1:0] count;
      logic [RATIO_W-1:0] ratio;
      logic               done_ack;
   } learn_cmd_type;

   typedef struct packed {
      logic       busy;
      logic       done;
      bounds_type bounds;
   } learn_stat_type;

endpackage

@@ sv/hsslc_if.sv @@
// Handshake channel interfaces for pixel words and result words.
`timescale 1ns / 1ps
interface hsslc_req_if;
   logic                          valid;
   logic                          ready;
   logic                          opcode;
   logic [hsslc_pkg::SEL_W-1:0]   sig_select;
   logic [hsslc_pkg::PIX_W-1:0]   hue;
   logic [hsslc_pkg::PIX_W-1:0]   saturation;
   logic                          last_sample;

   modport source (output valid, opcode, sig_select, hue, saturation, last_sample,
                   input ready);
   modport sink   (input valid, opcode, sig_select, hue, saturation, last_sample,
                   output ready);
endinterface

interface hsslc_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                is_match;
   logic                                learn_done;
   logic signed [hsslc_pkg::OUT_W-1:0]  hue_low;
   logic signed [hsslc_pkg::OUT_W-1:0]  hue_high;
   logic signed [hsslc_pkg::OUT_W-1:0]  sat_low;
   logic signed [hsslc_pkg::OUT_W-1:0]  sat_high;

   modport source (output valid, is_match, learn_done, hue_low, hue_high, sat_low,
                   sat_high, input ready);
   modport sink   (input valid, is_match, learn_done, hue_low, hue_high, sat_low,
                   sat_high, output ready);
endinterface

@@ sv/hsslc_region_ram.sv @@
// Region sample memory: one write port, one read port with registered data.
`timescale 1ns / 1ps
module hsslc_region_ram (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [hsslc_pkg::ADDR_W-1:0]  wr_addr,
   input  hsslc_pkg::sample_type         wr_data,
   input  logic                          rd_en,
   input  logic [hsslc_pkg::ADDR_W-1:0]  rd_addr,
   output hsslc_pkg::sample_type         rd_data
);

   hsslc_pkg::sample_type region_mem [hsslc_pkg::REGION_PIXELS];
   hsslc_pkg::sample_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         region_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= region_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/hsslc_learn_engine.sv @@
// Learning sequencer: eight bound-search passes over the region memory.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module hsslc_learn_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  hsslc_pkg::learn_cmd_type      cmd,
   output hsslc_pkg::learn_stat_type     stat,
   output logic                          rd_en,
   output logic [hsslc_pkg::ADDR_W-1:0]  rd_addr,
   input  hsslc_pkg::sample_type         rd_data
);

   localparam int ADDR_W  = hsslc_pkg::ADDR_W;
   localparam int COUNT_W = hsslc_pkg::COUNT_W;
   localparam int NEED_W  = hsslc_pkg::NEED_W;
   localparam int BND_W   = hsslc_pkg::BND_W;
   localparam int OUT_W   = hsslc_pkg::OUT_W;
   localparam int STEP_W  = hsslc_pkg::STEP_W;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SCAN   = 6'b000010,
      ST_DRAIN  = 6'b000100,
      ST_UPDATE = 6'b001000,
      ST_WIDEN  = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   state_type                state_ff, state_in;
   logic [ADDR_W-1:0]        addr_ff, addr_in;
   logic [ADDR_W-1:0]        last_ff, last_in;
   logic                     empty_ff, empty_in;
   logic [NEED_W-1:0]        need_ff, need_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic                     rd_valid_ff, rd_valid_in;
   logic signed [BND_W-1:0]  hlo_ff, hlo_in, hhi_ff, hhi_in;
   logic signed [BND_W-1:0]  slo_ff, slo_in, shi_ff, shi_in;
   logic signed [BND_W-1:0]  hmid_ff, hmid_in, smid_ff, smid_in;
   logic [COUNT_W-1:0]       cnt_ff [4];
   logic [COUNT_W-1:0]       cnt_in [4];
   hsslc_pkg::bounds_type    result_ff, result_in;

   logic signed [BND_W-1:0]  pix_h, pix_s, step_s;
   logic signed [BND_W:0]    hsum, ssum;
   logic [BND_W:0]           hsum_adj, ssum_adj;
   logic [3:0]               pass;

   // Midpoint truncated toward zero, then widening about that midpoint.
   function automatic logic signed [OUT_W-1:0] widen(
      input logic signed [BND_W-1:0] mid,
      input logic signed [BND_W-1:0] bound,
      input logic [1:0]              factor
   );
      logic signed [OUT_W-1:0] m;
      logic signed [OUT_W-1:0] d;
      m = OUT_W'(mid);
      d = OUT_W'(bound) - m;
      return m + d * OUT_W'(factor);
   endfunction

   always_comb begin
      pix_h  = BND_W'(rd_data.hue);
      pix_s  = BND_W'(rd_data.sat);
      step_s = BND_W'(step_ff);
      hsum   = (BND_W + 1)'(hlo_ff) + (BND_W + 1)'(hhi_ff);
      ssum   = (BND_W + 1)'(slo_ff) + (BND_W + 1)'(shi_ff);
      hsum_adj = hsum + (BND_W + 1)'(hsum[BND_W]);
      ssum_adj = ssum + (BND_W + 1)'(ssum[BND_W]);
      for (int k = 0; k < 4; k++) begin
         pass[k] = (NEED_W'(cnt_ff[k]) * NEED_W'(hsslc_pkg::PASS_PERCENT)) > need_ff;
      end
   end

   always_comb begin
      state_in    = state_ff;
      addr_in     = addr_ff;
      last_in     = last_ff;
      empty_in    = empty_ff;
      need_in     = need_ff;
      step_in     = step_ff;
      hlo_in      = hlo_ff;
      hhi_in      = hhi_ff;
      slo_in      = slo_ff;
      shi_in      = shi_ff;
      hmid_in     = hmid_ff;
      smid_in     = smid_ff;
      result_in   = result_ff;
      rd_valid_in = (state_ff == ST_SCAN);
      for (int k = 0; k < 4; k++) begin
         cnt_in[k] = cnt_ff[k];
      end

      if (rd_valid_ff) begin
         if (pix_h > hlo_ff) cnt_in[0] = cnt_ff[0] + COUNT_W'(1);
         if (pix_h < hhi_ff) cnt_in[1] = cnt_ff[1] + COUNT_W'(1);
         if (pix_s > slo_ff) cnt_in[2] = cnt_ff[2] + COUNT_W'(1);
         if (pix_s < shi_ff) cnt_in[3] = cnt_ff[3] + COUNT_W'(1);
      end

      case (state_ff)
         ST_IDLE: begin
            if (cmd.start) begin
               need_in  = NEED_W'(cmd.ratio) * NEED_W'(cmd.count);
               last_in  = ADDR_W'(cmd.count - COUNT_W'(1));
               empty_in = (cmd.count == '0);
               step_in  = hsslc_pkg::FIRST_STEP;
               addr_in  = '0;
               hlo_in   = '0;
               hhi_in   = '0;
               slo_in   = '0;
               shi_in   = '0;
               for (int k = 0; k < 4; k++) begin
                  cnt_in[k] = '0;
               end
               state_in = (cmd.count == '0) ? ST_UPDATE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            addr_in = addr_ff + ADDR_W'(1);
            if (addr_ff == last_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            hmid_in = hsum_adj[BND_W:1];
            smid_in = ssum_adj[BND_W:1];
            hlo_in  = pass[0] ? hlo_ff + step_s : hlo_ff - step_s;
            hhi_in  = pass[1] ? hhi_ff - step_s : hhi_ff + step_s;
            slo_in  = pass[2] ? slo_ff + step_s : slo_ff - step_s;
            shi_in  = pass[3] ? shi_ff - step_s : shi_ff + step_s;
            step_in = step_ff >> 1;
            addr_in = '0;
            for (int k = 0; k < 4; k++) begin
               cnt_in[k] = '0;
            end
            if (step_ff == STEP_W'(1)) begin
               state_in = ST_WIDEN;
            end else begin
               state_in = empty_ff ? ST_UPDATE : ST_SCAN;
            end
         end
         ST_WIDEN: begin
            result_in.hue_low  = widen(hmid_ff, hlo_ff, 2'(hsslc_pkg::HUE_WIDEN));
            result_in.hue_high = widen(hmid_ff, hhi_ff, 2'(hsslc_pkg::HUE_WIDEN));
            result_in.sat_low  = widen(smid_ff, slo_ff, 2'(hsslc_pkg::SAT_WIDEN));
            result_in.sat_high = widen(smid_ff, shi_ff, 2'(hsslc_pkg::SAT_WIDEN));
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (cmd.done_ack) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_valid_ff <= rd_valid_in;
      end
      addr_ff   <= addr_in;
      last_ff   <= last_in;
      empty_ff  <= empty_in;
      need_ff   <= need_in;
      step_ff   <= step_in;
      hlo_ff    <= hlo_in;
      hhi_ff    <= hhi_in;
      slo_ff    <= slo_in;
      shi_ff    <= shi_in;
      hmid_ff   <= hmid_in;
      smid_ff   <= smid_in;
      result_ff <= result_in;
      for (int k = 0; k < 4; k++) begin
         cnt_ff[k] <= cnt_in[k];
      end
   end

   assign rd_en       = (state_ff == ST_SCAN);
   assign rd_addr     = addr_ff;
   assign stat.busy   = (state_ff != ST_IDLE);
   assign stat.done   = (state_ff == ST_DONE);
   assign stat.bounds = result_ff;

   `HSSLC_ASSERT_IMPLIES(a_scan_in_region, clock, reset, state_ff == ST_SCAN, addr_ff <= last_ff)
   `HSSLC_ASSERT_IMPLIES(a_data_after_scan, clock, reset, rd_valid_ff, $past(state_ff) == ST_SCAN)
   `HSSLC_ASSERT_NEXT(a_start_busy, clock, reset, cmd.start && state_ff == ST_IDLE, state_ff != ST_IDLE)

endmodule

@@ sv/hue_sat_signature_learn_classify_core.sv @@
// Top level of the hue/saturation color signature learner and classifier.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// This block holds three hue/saturation color signatures and classifies pixels
// against them. A classify word is answered with one result word carrying the
// match bit and the bounds of the selected signature. Learn words are written
// into a 4096-entry region memory, one per cycle while input is not held off,
// and produce no result until the word marked last_sample closes the region.
// That word starts eight search passes if its sig_select names a signature;
// each pass streams all n stored samples through the single read port of the
// region memory, and no input word is taken until the result word with
// learn_done set appears. Classify and ordinary learn words are taken one per
// cycle while no learning runs and the output register is empty or its result
// is being taken in the same cycle. Samples beyond the memory size are dropped,
// but the last word still starts learning. The ratio register (byte address 0)
// sets the percentage of region pixels that must pass each bound; it resets to
// 80 and should be written only while idle.
module hue_sat_signature_learn_classify_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [hsslc_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [hsslc_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [hsslc_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                              csr_pready,
   hsslc_req_if.sink                         req_bus,
   hsslc_rsp_if.source                       rsp_bus
);

   localparam int COUNT_W = hsslc_pkg::COUNT_W;
   localparam int ADDR_W  = hsslc_pkg::ADDR_W;
   localparam int OUT_W   = hsslc_pkg::OUT_W;
   localparam int RATIO_W = hsslc_pkg::RATIO_W;
   localparam int SEL_W   = hsslc_pkg::SEL_W;

   // Configuration register.
   logic [RATIO_W-1:0] ratio_ff, ratio_in;
   logic               csr_hit;

   // Region bookkeeping and signature table.
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [COUNT_W-1:0]    n_stored;
   logic [SEL_W-1:0]      learn_sel_ff, learn_sel_in;
   hsslc_pkg::bounds_type sig_bounds_ff [hsslc_pkg::NUM_SIGNATURES];

   // Output register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_match_ff, rsp_match_in;
   logic                  rsp_done_ff, rsp_done_in;
   hsslc_pkg::bounds_type rsp_bounds_ff, rsp_bounds_in;

   logic                  accept, learn_acc, classify_acc;
   logic                  room, sel_ok, out_free, learn_load;
   hsslc_pkg::bounds_type sel_bounds;
   logic signed [OUT_W-1:0] pix_h, pix_s;
   logic                  in_range;

   hsslc_pkg::learn_cmd_type  cmd;
   hsslc_pkg::learn_stat_type stat;
   hsslc_pkg::sample_type     wr_sample, rd_sample;
   logic                      ram_rd_en;
   logic [ADDR_W-1:0]         ram_rd_addr;

   // The register file answers at once; a write lands in the access cycle.
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[hsslc_pkg::CSR_ADDR_W-1:2] == hsslc_pkg::CSR_RATIO_IDX);
   assign csr_prdata = csr_hit ? hsslc_pkg::CSR_DATA_W'(ratio_ff) : '0;

   always_comb begin
      ratio_in = ratio_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         ratio_in = csr_pwdata[RATIO_W-1:0];
      end
   end

   // Input words are held off while learning runs or while a finished result
   // cannot leave the output register.
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = !stat.busy && out_free;
   assign accept        = req_bus.valid && req_bus.ready;
   assign learn_acc     = accept && (req_bus.opcode == hsslc_pkg::OP_LEARN);
   assign classify_acc  = accept && (req_bus.opcode == hsslc_pkg::OP_CLASSIFY);
   assign sel_ok        = (req_bus.sig_select < SEL_W'(hsslc_pkg::NUM_SIGNATURES));
   assign room          = (count_ff < COUNT_W'(hsslc_pkg::REGION_PIXELS));
   assign n_stored      = room ? count_ff + COUNT_W'(1) : count_ff;
   assign learn_load    = stat.done && out_free;

   assign wr_sample.hue = req_bus.hue;
   assign wr_sample.sat = req_bus.saturation;

   assign cmd.start    = learn_acc && req_bus.last_sample && sel_ok;
   assign cmd.count    = n_stored;
   assign cmd.ratio    = ratio_ff;
   assign cmd.done_ack = out_free;

   always_comb begin
      count_in     = count_ff;
      learn_sel_in = learn_sel_ff;
      if (learn_acc) begin
         count_in = req_bus.last_sample ? '0 : n_stored;
         if (cmd.start) begin
            learn_sel_in = req_bus.sig_select;
         end
      end
   end

   // Classification against the selected signature, inclusive on both ends.
   always_comb begin
      sel_bounds = sel_ok ? sig_bounds_ff[req_bus.sig_select] : '0;
      pix_h      = OUT_W'(req_bus.hue);
      pix_s      = OUT_W'(req_bus.saturation);
      in_range   = (pix_h >= sel_bounds.hue_low) && (pix_h <= sel_bounds.hue_high) &&
                   (pix_s >= sel_bounds.sat_low) && (pix_s <= sel_bounds.sat_high);
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_match_in  = rsp_match_ff;
      rsp_done_in   = rsp_done_ff;
      rsp_bounds_in = rsp_bounds_ff;
      if (classify_acc) begin
         rsp_valid_in  = 1'b1;
         rsp_match_in  = sel_ok && in_range;
         rsp_done_in   = 1'b0;
         rsp_bounds_in = sel_bounds;
      end else if (learn_load) begin
         rsp_valid_in  = 1'b1;
         rsp_match_in  = 1'b0;
         rsp_done_in   = 1'b1;
         rsp_bounds_in = stat.bounds;
      end else if (rsp_bus.ready) begin
         rsp_valid_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_ff     <= hsslc_pkg::RATIO_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < hsslc_pkg::NUM_SIGNATURES; k++) begin
            sig_bounds_ff[k] <= '0;
         end
      end else begin
         ratio_ff     <= ratio_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (learn_load) begin
            sig_bounds_ff[learn_sel_ff] <= stat.bounds;
         end
      end
      learn_sel_ff  <= learn_sel_in;
      rsp_match_ff  <= rsp_match_in;
      rsp_done_ff   <= rsp_done_in;
      rsp_bounds_ff <= rsp_bounds_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.is_match   = rsp_match_ff;
   assign rsp_bus.learn_done = rsp_done_ff;
   assign rsp_bus.hue_low    = rsp_bounds_ff.hue_low;
   assign rsp_bus.hue_high   = rsp_bounds_ff.hue_high;
   assign rsp_bus.sat_low    = rsp_bounds_ff.sat_low;
   assign rsp_bus.sat_high   = rsp_bounds_ff.sat_high;

   // Learn words write the memory only while idle; the engine reads it only
   // while busy, so the two ports never touch the same entry at once.
   hsslc_region_ram u_region_ram (
      .clock   (clock),
      .wr_en   (learn_acc && room),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (wr_sample),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (rd_sample)
   );

   hsslc_learn_engine u_learn_engine (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .stat    (stat),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (rd_sample)
   );

   `HSSLC_ASSERT_IMPLIES(a_no_accept_busy, clock, reset, accept, !stat.busy)
   `HSSLC_ASSERT_IMPLIES(a_count_bound, clock, reset, 1'b1, count_ff <= COUNT_W'(hsslc_pkg::REGION_PIXELS))
   `HSSLC_ASSERT_NEXT(a_learn_result, clock, reset, learn_load, rsp_valid_ff && rsp_done_ff && !rsp_match_ff)

endmodule
